// ===== hdl/ctz_pkg.sv =====
package ctz_pkg;

	// Byte classes worked out by the front end. End of source is a class of its own.
	typedef enum logic [3:0] {
		CLS_LPAREN,
		CLS_RPAREN,
		CLS_ADD,
		CLS_SUB,
		CLS_MUL,
		CLS_DIV,
		CLS_REM,
		CLS_QUOTE,
		CLS_BLANK,
		CLS_LETTER,
		CLS_DIGIT,
		CLS_BAD,
		CLS_EOS
	} cls_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_STR,
		MODE_IDENT,
		MODE_NUM
	} mode_t;

	localparam logic [3:0] KIND_EOF    = 4'd0;
	localparam logic [3:0] KIND_LPAREN = 4'd1;
	localparam logic [3:0] KIND_RPAREN = 4'd2;
	localparam logic [3:0] KIND_ADD    = 4'd3;
	localparam logic [3:0] KIND_SUB    = 4'd4;
	localparam logic [3:0] KIND_MUL    = 4'd5;
	localparam logic [3:0] KIND_DIV    = 4'd6;
	localparam logic [3:0] KIND_REM    = 4'd7;
	localparam logic [3:0] KIND_STRING = 4'd8;
	localparam logic [3:0] KIND_IDENT  = 4'd9;
	localparam logic [3:0] KIND_NUMBER = 4'd10;
	localparam logic [3:0] KIND_ERROR  = 4'd11;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_ADD    = 8'h2B;
	localparam logic [7:0] CH_SUB    = 8'h2D;
	localparam logic [7:0] CH_MUL    = 8'h2A;
	localparam logic [7:0] CH_DIV    = 8'h2F;
	localparam logic [7:0] CH_REM    = 8'h25;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;

	// One classified source item as it travels through the queue.
	typedef struct packed {
		logic [7:0] ch;
		cls_t       cls;
	} item_t;

	// One result as the scanner forms it.
	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] ch;
		logic       bv;
		logic       tend;
	} res_t;

endpackage

// ===== hdl/ctz_front.sv =====
module ctz_front
	import ctz_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] source_byte,
	input  logic       end_of_source,
	input  logic       src_valid,
	output logic       src_stall,
	output logic       push,
	output item_t      push_item,
	input  logic       q_full
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_c;
	logic  load;

	always_comb begin
		item_c.ch = source_byte;
		if (end_of_source) begin
			item_c.cls = CLS_EOS;
		end else begin
			unique case (source_byte)
				CH_LPAREN: item_c.cls = CLS_LPAREN;
				CH_RPAREN: item_c.cls = CLS_RPAREN;
				CH_ADD:    item_c.cls = CLS_ADD;
				CH_SUB:    item_c.cls = CLS_SUB;
				CH_MUL:    item_c.cls = CLS_MUL;
				CH_DIV:    item_c.cls = CLS_DIV;
				CH_REM:    item_c.cls = CLS_REM;
				CH_QUOTE:  item_c.cls = CLS_QUOTE;
				CH_SPACE, CH_NL, CH_TAB: item_c.cls = CLS_BLANK;
				default: begin
					if ((source_byte >= 8'h61 && source_byte <= 8'h7A) ||
					    (source_byte >= 8'h41 && source_byte <= 8'h5A) ||
					    source_byte == CH_UNDER)
						item_c.cls = CLS_LETTER;
					else if (source_byte >= 8'h30 && source_byte <= 8'h39)
						item_c.cls = CLS_DIGIT;
					else
						item_c.cls = CLS_BAD;
				end
			endcase
		end
	end

	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;
	assign src_stall = valid_s1 && q_full;
	assign load      = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_c;
		end
	end

endmodule

// ===== hdl/ctz_queue.sv =====
module ctz_queue
	import ctz_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= bump(wr_q);
			if (pop)
				rd_q <= bump(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule

// ===== hdl/ctz_back.sv =====
module ctz_back
	import ctz_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  item_t      head_item,
	output logic       pop,
	output logic       tok_valid,
	input  logic       tok_stall,
	output logic [3:0] token_kind,
	output logic [7:0] content_byte,
	output logic       byte_valid,
	output logic       token_end,
	output logic       run_last
);

	mode_t mode_q, mode_d;
	logic  halted_q, halted_d;
	logic  phase_q, phase_d;
	logic  out_valid_q, out_valid_d;
	res_t  out_q;
	logic  last_q;

	// idle-mode scan of the head item
	logic  idle_emit, idle_halt;
	mode_t idle_mode;
	res_t  idle_res;

	res_t       r0, r1;
	logic [1:0] n;
	mode_t      scan_mode_nxt;
	logic       scan_halt_nxt;

	logic out_free;
	logic load;
	logic sel_r1;
	logic last_d;

	always_comb begin
		idle_emit = 1'b1;
		idle_halt = 1'b0;
		idle_mode = MODE_IDLE;
		idle_res  = '{kind: KIND_EOF, ch: 8'h00, bv: 1'b0, tend: 1'b1};
		unique case (head_item.cls)
			CLS_EOS:    idle_res.kind = KIND_EOF;
			CLS_LPAREN: idle_res.kind = KIND_LPAREN;
			CLS_RPAREN: idle_res.kind = KIND_RPAREN;
			CLS_ADD:    idle_res.kind = KIND_ADD;
			CLS_SUB:    idle_res.kind = KIND_SUB;
			CLS_MUL:    idle_res.kind = KIND_MUL;
			CLS_DIV:    idle_res.kind = KIND_DIV;
			CLS_REM:    idle_res.kind = KIND_REM;
			CLS_QUOTE: begin
				idle_emit = 1'b0;
				idle_mode = MODE_STR;
			end
			CLS_BLANK:  idle_emit = 1'b0;
			CLS_LETTER: begin
				idle_mode = MODE_IDENT;
				idle_res  = '{kind: KIND_IDENT, ch: head_item.ch, bv: 1'b1, tend: 1'b0};
			end
			CLS_DIGIT: begin
				idle_mode = MODE_NUM;
				idle_res  = '{kind: KIND_NUMBER, ch: head_item.ch, bv: 1'b1, tend: 1'b0};
			end
			default: begin
				idle_res.kind = KIND_ERROR;
				idle_halt     = 1'b1;
			end
		endcase
	end

	always_comb begin
		r0            = idle_res;
		r1            = idle_res;
		n             = {1'b0, idle_emit};
		scan_mode_nxt = idle_mode;
		scan_halt_nxt = idle_halt;
		unique case (mode_q)
			MODE_STR: begin
				n = 2'd1;
				if (head_item.cls == CLS_EOS) begin
					r0            = '{kind: KIND_ERROR, ch: 8'h00, bv: 1'b0, tend: 1'b1};
					scan_mode_nxt = MODE_IDLE;
					scan_halt_nxt = 1'b1;
				end else if (head_item.cls == CLS_QUOTE) begin
					r0            = '{kind: KIND_STRING, ch: 8'h00, bv: 1'b0, tend: 1'b1};
					scan_mode_nxt = MODE_IDLE;
					scan_halt_nxt = 1'b0;
				end else begin
					r0            = '{kind: KIND_STRING, ch: head_item.ch, bv: 1'b1, tend: 1'b0};
					scan_mode_nxt = MODE_STR;
					scan_halt_nxt = 1'b0;
				end
			end
			MODE_IDENT: begin
				if (head_item.cls == CLS_LETTER || head_item.cls == CLS_DIGIT) begin
					r0            = '{kind: KIND_IDENT, ch: head_item.ch, bv: 1'b1, tend: 1'b0};
					n             = 2'd1;
					scan_mode_nxt = MODE_IDENT;
					scan_halt_nxt = 1'b0;
				end else begin
					r0 = '{kind: KIND_IDENT, ch: 8'h00, bv: 1'b0, tend: 1'b1};
					n  = 2'd1 + {1'b0, idle_emit};
				end
			end
			MODE_NUM: begin
				if (head_item.cls == CLS_DIGIT) begin
					r0            = '{kind: KIND_NUMBER, ch: head_item.ch, bv: 1'b1, tend: 1'b0};
					n             = 2'd1;
					scan_mode_nxt = MODE_NUM;
					scan_halt_nxt = 1'b0;
				end else begin
					r0 = '{kind: KIND_NUMBER, ch: 8'h00, bv: 1'b0, tend: 1'b1};
					n  = 2'd1 + {1'b0, idle_emit};
				end
			end
			default: begin
				r0 = idle_res;
			end
		endcase
	end

	assign out_free = !out_valid_q || !tok_stall;

	// control: pop / load / state commit
	always_comb begin
		pop      = 1'b0;
		load     = 1'b0;
		sel_r1   = 1'b0;
		last_d   = 1'b1;
		mode_d   = mode_q;
		halted_d = halted_q;
		phase_d  = phase_q;
		if (head_valid && halted_q) begin
			pop = 1'b1;
		end else if (head_valid && out_free) begin
			unique case (n)
				2'd0: begin
					pop      = 1'b1;
					mode_d   = scan_mode_nxt;
					halted_d = scan_halt_nxt;
				end
				2'd1: begin
					pop      = 1'b1;
					load     = 1'b1;
					mode_d   = scan_mode_nxt;
					halted_d = scan_halt_nxt;
				end
				default: begin
					load = 1'b1;
					if (!phase_q) begin
						last_d  = 1'b0;
						phase_d = 1'b1;
					end else begin
						sel_r1   = 1'b1;
						pop      = 1'b1;
						phase_d  = 1'b0;
						mode_d   = scan_mode_nxt;
						halted_d = scan_halt_nxt;
					end
				end
			endcase
		end
		out_valid_d = out_free ? load : out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			halted_q    <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q      <= mode_d;
			halted_q    <= halted_d;
			phase_q     <= phase_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= sel_r1 ? r1 : r0;
			last_q <= last_d;
		end
	end

	assign tok_valid    = out_valid_q;
	assign token_kind   = out_q.kind;
	assign content_byte = out_q.ch;
	assign byte_valid   = out_q.bv;
	assign token_end    = out_q.tend;
	assign run_last     = last_q;

endmodule

// ===== hdl/char_stream_tokenizer.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------------
// source   | src_valid / src_stall | source_byte, end_of_source
// tokens   | tok_valid / tok_stall | token_kind, content_byte, byte_valid, token_end,
//          |                       | run_last
//
// One source byte per cycle unless src_stall is high; an item that yields two
// results holds the queue head in the scanner until its second result is loaded,
// every other item is popped when it is scanned. From acceptance to first result
// an item passes the front register, the queue and the result register.
// arst_n clears the scan mode to idle, the halt flag, the queue and all valid bits.
// The queue lets the front keep accepting while the result side is stalled; the
// source stalls only once the queue and the front register are full.
module char_stream_tokenizer
	import ctz_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4   // classified items held between front and scanner
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] source_byte,
	input  logic       end_of_source,
	output logic       tok_valid,
	input  logic       tok_stall,
	output logic [3:0] token_kind,
	output logic [7:0] content_byte,
	output logic       byte_valid,
	output logic       token_end,
	output logic       run_last
);

	// front end -> queue
	logic  push;
	item_t push_item;
	logic  q_full;

	// queue -> scanner
	logic  head_valid;
	item_t head_item;
	logic  pop;

	// Front: registers each source request together with its byte class.
	ctz_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_byte   (source_byte),
		.end_of_source (end_of_source),
		.src_valid     (src_valid),
		.src_stall     (src_stall),
		.push          (push),
		.push_item     (push_item),
		.q_full        (q_full)
	);

	// Decouples classification from scanning so either side may stall.
	ctz_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// Back: scan mode and halt state, result formation and the result register.
	// A byte that closes an identifier or number gives the end-of-token result first
	// and then, if it yields one, its own idle-mode result from the same queue entry.
	ctz_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.content_byte (content_byte),
		.byte_valid   (byte_valid),
		.token_end    (token_end),
		.run_last     (run_last)
	);

endmodule

// ===== dv/tb_char_stream_tokenizer.sv =====
module tb_char_stream_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	import ctz_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_AFTER   = 400;      // requests accepted before the long hold
	localparam int HOLD_CYCLES  = 300;

	// One source request as queued for the driver.
	typedef struct {
		logic [7:0] ch;
		logic       eos;
	} src_req_t;

	// One token result as the scanner should present it.
	typedef struct {
		logic [3:0] kind;
		logic [7:0] ch;
		logic       bv;
		logic       tend;
		logic       last;
	} tok_rec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	logic [7:0] source_byte = 8'h00;
	logic       end_of_source = 1'b0;
	logic       tok_valid;
	logic       tok_stall = 1'b0;
	logic [3:0] token_kind;
	logic [7:0] content_byte;
	logic       byte_valid;
	logic       token_end;
	logic       run_last;

	src_req_t pending_reqs[$];
	tok_rec_t expected_tokens[$];
	tok_rec_t req_tokens[$];          // results of the request being scanned

	// Scanner state as predicted
	mode_t pred_mode = MODE_IDLE;
	logic  pred_halted = 1'b0;

	int accepted_reqs = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// Sender burst/gap and receiver stall pattern state
	int burst_left = 0;
	int gap_left = 0;
	int stall_seg = 0;
	int stall_style = 0;
	int stall_phase = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	char_stream_tokenizer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.source_byte  (source_byte),
		.end_of_source(end_of_source),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.content_byte (content_byte),
		.byte_valid   (byte_valid),
		.token_end    (token_end),
		.run_last     (run_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Character classes
	// ------------------------------------------------------------------
	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_word_char(logic [7:0] c);
		return is_letter(c) || is_digit(c) || c == CH_UNDER;
	endfunction

	// Anything the idle scanner has no rule for; these halt the block.
	function automatic logic is_unknown(logic [7:0] c);
		case (c)
			CH_LPAREN, CH_RPAREN, CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_REM,
			CH_QUOTE, CH_SPACE, CH_NL, CH_TAB: return 1'b0;
			default: return !is_word_char(c);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Token predictor
	// ------------------------------------------------------------------
	function void add_token(logic [3:0] kind, logic [7:0] ch, logic bv, logic tend);
		req_tokens.push_back('{kind, ch, bv, tend, 1'b0});
	endfunction

	// Idle-mode scan; also used to rescan the byte that closed an ident or number.
	function void scan_idle(logic [7:0] c, logic eos);
		if (eos) begin
			add_token(KIND_EOF, 8'h00, 1'b0, 1'b1);
			return;
		end
		case (c)
			CH_LPAREN: add_token(KIND_LPAREN, 8'h00, 1'b0, 1'b1);
			CH_RPAREN: add_token(KIND_RPAREN, 8'h00, 1'b0, 1'b1);
			CH_ADD:    add_token(KIND_ADD, 8'h00, 1'b0, 1'b1);
			CH_SUB:    add_token(KIND_SUB, 8'h00, 1'b0, 1'b1);
			CH_MUL:    add_token(KIND_MUL, 8'h00, 1'b0, 1'b1);
			CH_DIV:    add_token(KIND_DIV, 8'h00, 1'b0, 1'b1);
			CH_REM:    add_token(KIND_REM, 8'h00, 1'b0, 1'b1);
			CH_QUOTE:  pred_mode = MODE_STR;
			CH_SPACE, CH_NL, CH_TAB: ;
			default: begin
				if (is_letter(c) || c == CH_UNDER) begin
					pred_mode = MODE_IDENT;
					add_token(KIND_IDENT, c, 1'b1, 1'b0);
				end else if (is_digit(c)) begin
					pred_mode = MODE_NUM;
					add_token(KIND_NUMBER, c, 1'b1, 1'b0);
				end else begin
					add_token(KIND_ERROR, 8'h00, 1'b0, 1'b1);
					pred_halted = 1'b1;
				end
			end
		endcase
	endfunction

	// Works out the results of one accepted request and queues them.
	function void scan_source_req(logic [7:0] c, logic eos);
		req_tokens.delete();
		if (pred_halted)
			return;
		case (pred_mode)
			MODE_STR: begin
				if (eos) begin
					// unterminated string
					add_token(KIND_ERROR, 8'h00, 1'b0, 1'b1);
					pred_halted = 1'b1;
					pred_mode = MODE_IDLE;
				end else if (c == CH_QUOTE) begin
					add_token(KIND_STRING, 8'h00, 1'b0, 1'b1);
					pred_mode = MODE_IDLE;
				end else begin
					add_token(KIND_STRING, c, 1'b1, 1'b0);
				end
			end
			MODE_IDENT: begin
				if (!eos && is_word_char(c)) begin
					add_token(KIND_IDENT, c, 1'b1, 1'b0);
				end else begin
					add_token(KIND_IDENT, 8'h00, 1'b0, 1'b1);
					pred_mode = MODE_IDLE;
					scan_idle(c, eos);
				end
			end
			MODE_NUM: begin
				if (!eos && is_digit(c)) begin
					add_token(KIND_NUMBER, c, 1'b1, 1'b0);
				end else begin
					add_token(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
					pred_mode = MODE_IDLE;
					scan_idle(c, eos);
				end
			end
			default: scan_idle(c, eos);
		endcase
		if (req_tokens.size() > 0)
			req_tokens[req_tokens.size() - 1].last = 1'b1;
		foreach (req_tokens[i])
			expected_tokens.push_back(req_tokens[i]);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building blocks
	// ------------------------------------------------------------------
	function void push_char(logic [7:0] c);
		pending_reqs.push_back('{c, 1'b0});
	endfunction

	// End of source; the byte lane carries junk that must be ignored.
	function void push_eos();
		pending_reqs.push_back('{8'($urandom_range(0, 255)), 1'b1});
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return "a" + 8'($urandom_range(0, 25));
		return "A" + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return "0" + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_word_char();
		case ($urandom_range(0, 3))
			0: return rand_digit();
			1: return CH_UNDER;
			default: return rand_letter();
		endcase
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 6))
			0: return CH_LPAREN;
			1: return CH_RPAREN;
			2: return CH_ADD;
			3: return CH_SUB;
			4: return CH_MUL;
			5: return CH_DIV;
			default: return CH_REM;
		endcase
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 2))
			0: return CH_SPACE;
			1: return CH_NL;
			default: return CH_TAB;
		endcase
	endfunction

	// Mostly short tokens, now and then a long one.
	function automatic int rand_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(7, 24);
		return $urandom_range(1, 6);
	endfunction

	function void push_ident();
		int n;
		n = rand_len();
		push_char(($urandom_range(0, 4) == 0) ? CH_UNDER : rand_letter());
		for (int i = 1; i < n; i++)
			push_char(rand_word_char());
	endfunction

	function void push_number();
		int n;
		n = rand_len();
		for (int i = 0; i < n; i++)
			push_char(rand_digit());
	endfunction

	// String body may hold any byte but the quote, high half included.
	function void push_string();
		int n;
		logic [7:0] c;
		n = ($urandom_range(0, 5) == 0) ? 0 : rand_len();
		push_char(CH_QUOTE);
		for (int i = 0; i < n; i++) begin
			do
				c = 8'($urandom_range(0, 255));
			while (c == CH_QUOTE);
			push_char(c);
		end
		push_char(CH_QUOTE);
	endfunction

	function automatic logic [7:0] rand_unknown();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (!is_unknown(c));
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Request list and end of run
	// ------------------------------------------------------------------
	initial begin
		int base;

		// Directed: every operator, every blank, empty string, word chars
		// at their edges, ident and number closed by end of source, a number
		// running into a letter, and a string body with extreme bytes.
		push_char(CH_LPAREN);
		push_char(CH_RPAREN);
		push_char(CH_ADD);
		push_char(CH_SUB);
		push_char(CH_MUL);
		push_char(CH_DIV);
		push_char(CH_REM);
		push_char(CH_SPACE);
		push_char(CH_NL);
		push_char(CH_TAB);
		push_char(CH_QUOTE);
		push_char(CH_QUOTE);
		push_char(CH_UNDER);
		push_char("A");
		push_char("z");
		push_char("9");
		push_eos();
		push_char("0");
		push_char("9");
		push_char("a");
		push_char(CH_ADD);
		push_char("7");
		push_eos();
		push_char(CH_QUOTE);
		push_char(8'h00);
		push_char(8'hFF);
		push_char(CH_QUOTE);

		// Random: well-formed token streams; tokens often abut, so
		// idents swallow digits and numbers get cut short by letters.
		base = pending_reqs.size();
		while (pending_reqs.size() - base < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4:  push_ident();
				5, 6, 7, 8:     push_number();
				9, 10, 11:      push_string();
				12, 13, 14, 15: push_char(rand_op());
				16, 17, 18:     push_char(rand_blank());
				default:        push_eos();
			endcase
		end

		// Error can only happen once per reset, so it closes the run.
		case ($urandom_range(0, 2))
			0: push_char(rand_unknown());
			1: begin
				push_ident();
				push_char(rand_unknown());
			end
			default: begin
				push_char(CH_QUOTE);
				push_char(rand_letter());
				push_eos();
			end
		endcase
		// Halted: these must produce nothing.
		for (int i = 0; i < 6; i++) begin
			if (i == 3)
				push_eos();
			else
				push_char(8'($urandom_range(0, 255)));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || src_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_tokens.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Source driver: bursts of requests separated by random gaps. A
	// stalled request is held unchanged. Prediction happens at the edge
	// where the request is taken.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		src_req_t nxt;
		if (!arst_n) begin
			src_valid <= 1'b0;
			source_byte <= 8'h00;
			end_of_source <= 1'b0;
		end else begin
			if (src_valid && !src_stall) begin
				scan_source_req(source_byte, end_of_source);
				accepted_reqs <= accepted_reqs + 1;
			end
			if (!(src_valid && src_stall)) begin
				if (gap_left > 0) begin
					src_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() > 0) begin
					nxt = pending_reqs.pop_front();
					src_valid <= 1'b1;
					source_byte <= nxt.ch;
					end_of_source <= nxt.eos;
					if (burst_left <= 1) begin
						// a quarter of the bursts run straight into the next
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Token receiver stall: segments of no stall, coin-flip stall and a
	// one-in-three pattern; once, a long hold so the queue backs up and
	// the source side gets stalled.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_stall <= 1'b0;
		end else if (!hold_done && accepted_reqs >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			tok_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			tok_stall <= (hold_left > 1);
		end else begin
			if (stall_seg == 0) begin
				stall_style <= $urandom_range(0, 2);
				stall_seg <= $urandom_range(5, 60);
			end else begin
				stall_seg <= stall_seg - 1;
			end
			case (stall_style)
				0: tok_stall <= 1'b0;
				1: tok_stall <= 1'($urandom_range(0, 1));
				default: tok_stall <= (stall_phase == 0);
			endcase
			stall_phase <= (stall_phase == 2) ? 0 : stall_phase + 1;
		end
	end

	// ------------------------------------------------------------------
	// Token checker: every taken result against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		tok_rec_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected token, expected none",
					$time);
				$display("%0t: got kind=%0d ch=%02h bv=%0b end=%0b last=%0b",
					$time, token_kind, content_byte, byte_valid, token_end, run_last);
				mismatch_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (token_kind !== want.kind || content_byte !== want.ch ||
						byte_valid !== want.bv || token_end !== want.tend ||
						run_last !== want.last) begin
					$display("%0t: token mismatch, expected kind=%0d ch=%02h bv=%0b end=%0b last=%0b",
						$time, want.kind, want.ch, want.bv, want.tend, want.last);
					$display("%0t:                 got      kind=%0d ch=%02h bv=%0b end=%0b last=%0b",
						$time, token_kind, content_byte, byte_valid, token_end, run_last);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, expected_tokens.size());
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
